@@ rtl/vca_pkg.sv @@
// Package: shared types and constants of the voice channel allocator.
`default_nettype none
package vca_pkg;
    localparam logic [31:0] NO_OWNER  = 32'hFFFF_FFFF;
    localparam logic [7:0]  PRIO_FREE = 8'hFF;

    typedef enum logic [1:0] {
        CMD_REQUEST = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_STOP    = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] requester_id;
        logic [2:0]  type_mask;
        logic [6:0]  priority_req;
        logic [31:0] duration;
        logic [31:0] wave_crc;
    } t_req;

    typedef struct packed {
        logic        granted;
        logic [2:0]  channel;
        logic [2:0]  wave_slot;
        logic        wave_reload;
        logic [5:0]  channel_mask;
    } t_rsp;

    // One channel record as held in channel memory
    typedef struct packed {
        logic [31:0] owner;
        logic [31:0] deadline;
        logic [7:0]  prio;
        logic [3:0]  wave;
    } t_chan;

    typedef struct packed {
        logic        loaded;
        logic [31:0] crc;
        logic [2:0]  usage;
    } t_slot;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS_OWN,
        ST_PASS_DUE,
        ST_PASS_STEAL,
        ST_SLOT_HIT,
        ST_SLOT_FREE,
        ST_WRITE_CHAN,
        ST_TICK_CLR,
        ST_TICK_CHAN,
        ST_TICK_USE,
        ST_STOP,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

@@ rtl/vca_if.sv @@
// Interface: valid/ready channel carrying one payload.
`default_nettype none
interface vca_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/voice_channel_allocator.sv @@
// Top level: voice channel allocator with waveform slot sharing.
`default_nettype none
// Accepts one command at a time and returns one result per command. Channel and
// slot records live in two small synchronous memories, read one entry per cycle.
// A request scans the channels up to three times and the slots up to twice, then
// writes the channel record; a tick scans the slots twice and the channels once,
// and skips the scans when no channel is in use; a stop scans the channels once.
// After reset a clearing pass initialises both memories before the first
// command is accepted. A result waits in an output register while the
// block is free to take the next command; a command finishing while the
// previous result still waits holds until that result transfers.
module voice_channel_allocator #(
    parameter int NUM_CHANNELS    = 6,
    parameter int NUM_WAVE_SLOTS  = 5,
    parameter int NORMAL_CHANNELS = 4,
    parameter int MOD_CHANNELS    = 1
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vca_if.sink       i_cmd,
    vca_if.source     o_rsp
);
    import vca_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SW = (NUM_WAVE_SLOTS > 1) ? $clog2(NUM_WAVE_SLOTS) : 1;

    // memories
    t_chan r_cmem [NUM_CHANNELS];
    t_slot r_smem [NUM_WAVE_SLOTS];
    t_chan r_crd;
    t_slot r_srd;
    logic [CW-1:0] c_raddr, c_waddr;
    logic [SW-1:0] s_raddr, s_waddr;
    logic          c_we, s_we;
    t_chan         c_wd;
    t_slot         s_wd;

    always_ff @(posedge i_clk) begin
        if (c_we) r_cmem[c_waddr] <= c_wd;
        r_crd <= r_cmem[c_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (s_we) r_smem[s_waddr] <= s_wd;
        r_srd <= r_smem[s_raddr];
    end

    // control
    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [3:0] r_idx, n_idx;       // issue index
    logic       r_rv, n_rv;         // read data valid for r_ridx
    logic [3:0] r_ridx, n_ridx;
    logic       r_init, n_init;
    logic [3:0] r_icnt, n_icnt;
    logic       r_found, n_found;
    logic [CW-1:0] r_ch, n_ch;
    logic [31:0]   r_bestdl, n_bestdl;
    logic [SW-1:0] r_slot, n_slot;
    logic          r_reload, n_reload;
    logic          r_sfound, n_sfound;
    logic [31:0] r_tick, n_tick;
    logic        r_inuse, n_inuse;
    logic [5:0]  r_mask, n_mask;
    logic [2:0]  r_use [NUM_WAVE_SLOTS];
    logic [2:0]  n_use [NUM_WAVE_SLOTS];
    logic        r_ovalid, n_ovalid;
    t_rsp        r_rsp, n_rsp;

    function automatic logic [2:0] kind_of(input logic [3:0] ch);
        if (int'(ch) < NORMAL_CHANNELS) return 3'b001;
        if (int'(ch) < NORMAL_CHANNELS + MOD_CHANNELS) return 3'b011;
        return 3'b100;
    endfunction

    assign i_cmd.ready = (r_state == ST_IDLE) && r_init;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    logic          match;
    logic [5:0]    bit_r;
    logic [SW-1:0] wslot;

    always_comb begin
        n_state = r_state; n_req = r_req; n_idx = r_idx; n_rv = 1'b0;
        n_ridx = r_idx; n_init = r_init; n_icnt = r_icnt; n_found = r_found;
        n_ch = r_ch; n_bestdl = r_bestdl; n_slot = r_slot; n_reload = r_reload;
        n_sfound = r_sfound; n_tick = r_tick; n_inuse = r_inuse; n_mask = r_mask;
        n_use = r_use; n_ovalid = r_ovalid; n_rsp = r_rsp;
        c_raddr = r_idx[CW-1:0]; s_raddr = r_idx[SW-1:0];
        c_we = 1'b0; c_waddr = r_ridx[CW-1:0]; c_wd = r_crd;
        s_we = 1'b0; s_waddr = r_ridx[SW-1:0]; s_wd = r_srd;
        match = (r_req.type_mask & kind_of(r_ridx)) != 3'b000;
        bit_r = 6'(1) << r_ridx;
        wslot = SW'(r_crd.wave - 4'd1);

        if (r_ovalid && o_rsp.ready) n_ovalid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!r_init) begin
                    if (int'(r_icnt) < NUM_CHANNELS) begin
                        c_we = 1'b1; c_waddr = r_icnt[CW-1:0];
                        c_wd = '{owner: NO_OWNER, deadline: '0, prio: PRIO_FREE,
                                 wave: '0};
                    end
                    if (int'(r_icnt) < NUM_WAVE_SLOTS) begin
                        s_we = 1'b1; s_waddr = r_icnt[SW-1:0]; s_wd = '0;
                    end
                    n_icnt = r_icnt + 4'd1;
                    if (int'(r_icnt) + 1 >= NUM_CHANNELS &&
                        int'(r_icnt) + 1 >= NUM_WAVE_SLOTS) n_init = 1'b1;
                end else if (i_cmd.valid && i_cmd.ready) begin
                    n_req = i_cmd.data; n_idx = '0; n_mask = '0; n_found = 1'b0;
                    n_sfound = 1'b0; n_reload = 1'b0; n_slot = '0;
                    case (t_cmd'(i_cmd.data.cmd))
                        CMD_REQUEST: n_state = ST_PASS_OWN;
                        CMD_TICK:    n_state = r_inuse ? ST_TICK_CLR : ST_DONE;
                        CMD_STOP:    n_state = ST_STOP;
                        default:     n_state = ST_DONE;
                    endcase
                end
            end
            ST_PASS_OWN, ST_PASS_DUE, ST_PASS_STEAL, ST_STOP, ST_TICK_CHAN: begin
                // issue read for r_idx, evaluate r_ridx when r_rv
                if (int'(r_idx) < NUM_CHANNELS) begin
                    n_idx = r_idx + 4'd1; n_rv = 1'b1;
                end
                if (r_rv) begin
                    case (r_state)
                        ST_PASS_OWN: if (!r_found && match &&
                                         r_crd.owner == r_req.requester_id) begin
                            n_found = 1'b1; n_ch = r_ridx[CW-1:0];
                        end
                        ST_PASS_DUE: if (!r_found && match &&
                                         r_tick >= r_crd.deadline) begin
                            n_found = 1'b1; n_ch = r_ridx[CW-1:0];
                        end
                        ST_PASS_STEAL: if (match && $signed(r_crd.prio) <=
                                           $signed({1'b0, r_req.priority_req}) &&
                                           (!r_found || r_crd.deadline < r_bestdl)) begin
                            n_found = 1'b1; n_ch = r_ridx[CW-1:0];
                            n_bestdl = r_crd.deadline;
                        end
                        ST_STOP: if (r_crd.owner == r_req.requester_id) begin
                            c_we = 1'b1; c_wd.deadline = '0; c_wd.wave = '0;
                            n_mask = r_mask | bit_r;
                        end
                        default: if (r_crd.deadline != '0) begin
                            if (r_tick > r_crd.deadline) begin
                                c_we = 1'b1;
                                c_wd = '{owner: NO_OWNER, deadline: '0,
                                         prio: PRIO_FREE, wave: '0};
                                n_mask = r_mask | bit_r;
                            end else if (r_crd.wave != '0) begin
                                if (int'(r_crd.wave) - 1 < NUM_WAVE_SLOTS &&
                                    n_use[wslot] != 3'd7)
                                    n_use[wslot] = n_use[wslot] + 3'd1;
                                n_inuse = 1'b1;
                            end
                        end
                    endcase
                end
                if (r_rv && int'(r_ridx) == NUM_CHANNELS - 1) begin
                    n_idx = '0; n_rv = 1'b0;
                    unique case (r_state)
                        ST_PASS_OWN:   if (!n_found) n_state = ST_PASS_DUE;
                                       else n_state = ST_SLOT_HIT;
                        ST_PASS_DUE:   if (!n_found) n_state = ST_PASS_STEAL;
                                       else n_state = ST_SLOT_HIT;
                        ST_PASS_STEAL: n_state = n_found ? ST_SLOT_HIT : ST_DONE;
                        ST_TICK_CHAN:  n_state = ST_TICK_USE;
                        default:       n_state = ST_DONE;
                    endcase
                end
            end
            ST_SLOT_HIT, ST_SLOT_FREE, ST_TICK_CLR, ST_TICK_USE: begin
                if (int'(r_idx) < NUM_WAVE_SLOTS) begin
                    n_idx = r_idx + 4'd1; n_rv = 1'b1;
                end
                if (r_rv && !r_sfound) begin
                    case (r_state)
                        ST_SLOT_HIT: if (r_srd.loaded && r_srd.crc == r_req.wave_crc) begin
                            n_sfound = 1'b1; n_slot = r_ridx[SW-1:0];
                            s_we = 1'b1; s_wd.usage = 3'd1;
                        end
                        ST_SLOT_FREE: if (!r_srd.loaded || r_srd.usage == 3'd0) begin
                            n_sfound = 1'b1; n_slot = r_ridx[SW-1:0]; n_reload = 1'b1;
                            s_we = 1'b1;
                            s_wd = '{loaded: 1'b1, crc: r_req.wave_crc, usage: 3'd1};
                        end
                        ST_TICK_CLR: begin
                            n_use[r_ridx[SW-1:0]] = 3'd0;
                        end
                        default: begin
                            s_we = 1'b1; s_wd.usage = r_use[r_ridx[SW-1:0]];
                        end
                    endcase
                end
                if (r_rv && int'(r_ridx) == NUM_WAVE_SLOTS - 1) begin
                    n_idx = '0; n_rv = 1'b0;
                    unique case (r_state)
                        ST_SLOT_HIT:  n_state = n_sfound ? ST_WRITE_CHAN : ST_SLOT_FREE;
                        ST_SLOT_FREE: n_state = ST_WRITE_CHAN;
                        ST_TICK_CLR: begin
                            n_state = ST_TICK_CHAN; n_inuse = 1'b0;
                        end
                        default:      n_state = ST_DONE;
                    endcase
                end
            end
            ST_WRITE_CHAN: begin
                c_we = 1'b1; c_waddr = r_ch;
                c_wd = '{owner: r_req.requester_id,
                         deadline: r_tick + r_req.duration,
                         prio: {1'b0, r_req.priority_req},
                         wave: 4'(r_slot) + 4'd1};
                n_inuse = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // the previous result must have left the output register
                if (!r_ovalid || o_rsp.ready) begin
                    n_rsp = '0;
                    if (t_cmd'(r_req.cmd) == CMD_REQUEST && r_found) begin
                        n_rsp.granted = 1'b1; n_rsp.channel = 3'(r_ch);
                        n_rsp.wave_slot = 3'(r_slot); n_rsp.wave_reload = r_reload;
                    end
                    if (t_cmd'(r_req.cmd) == CMD_TICK) n_tick = r_tick + 32'd1;
                    if (t_cmd'(r_req.cmd) == CMD_TICK || t_cmd'(r_req.cmd) == CMD_STOP)
                        n_rsp.channel_mask = r_mask;
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_init <= 1'b0; r_icnt <= '0; r_rv <= 1'b0;
            r_tick <= '0; r_inuse <= 1'b0; r_ovalid <= 1'b0; r_idx <= '0;
        end else begin
            r_state <= n_state; r_init <= n_init; r_icnt <= n_icnt; r_rv <= n_rv;
            r_tick <= n_tick; r_inuse <= n_inuse; r_ovalid <= n_ovalid;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_ridx <= n_ridx; r_found <= n_found; r_ch <= n_ch;
        r_bestdl <= n_bestdl; r_slot <= n_slot; r_reload <= n_reload;
        r_sfound <= n_sfound; r_mask <= n_mask; r_use <= n_use; r_rsp <= n_rsp;
    end
endmodule
`default_nettype wire
